// File: rtl/slr_pkg.sv
// Shared widths, payload types and helpers for the spring link relaxation pipeline.
package slr_pkg;

	localparam int PW        = 24;  // position / delta width, Q15.8
	localparam int AW        = 25;  // magnitude of a coordinate difference
	localparam int RLW       = 23;  // rest length width
	localparam int GW        = 16;  // gain width, Q0.16
	localparam int SQW       = 51;  // square-root remainder and root working width
	localparam int MW        = 26;  // link length width
	localparam int PRW       = 51;  // |d| * |err| width
	localparam int DW        = 68;  // divider remainder width
	localparam int QW        = 26;  // quotient width
	localparam int SQ_STEPS  = 25;
	localparam int DIV_STEPS = 26;

	localparam logic CFG_SPRING_GAIN   = 1'b0;
	localparam logic CFG_VERTICAL_GAIN = 1'b1;
	localparam logic [GW-1:0] SPRING_GAIN_RST   = 16'd6554;
	localparam logic [GW-1:0] VERTICAL_GAIN_RST = 16'd655;

	typedef struct packed {
		logic [2:0][PW-1:0] a;
		logic [2:0][PW-1:0] b;
		logic               pin_a;
		logic               pin_b;
	} pos_t;

	typedef struct packed {
		pos_t               pos;
		logic [2:0][AW-1:0] ad;
		logic [2:0]         sgn;
		logic [RLW-1:0]     rest;
		logic               vert;
		logic               coin;
		logic [SQW-1:0]     x;
		logic [SQW-1:0]     res;
	} sq_t;

	typedef struct packed {
		pos_t               pos;
		logic [2:0]         neg;
		logic [2:0][DW-1:0] rem;
		logic [MW-1:0]      den;
		logic [2:0][QW-1:0] q;
		logic               coin;
	} dv_t;

	function automatic logic [PW-1:0] sat24(input logic signed [27:0] v);
		logic [PW-1:0] r;
		if (v > 28'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (v < -28'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/slr_sqrt_cell.sv
// One bit-pair step of the pipelined integer square root.
module slr_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         step,
	input  logic               up_valid,
	output logic               up_hold,
	input  slr_pkg::sq_t       up_data,
	output logic               dn_valid,
	input  logic               dn_hold,
	output slr_pkg::sq_t       dn_data
);
	logic                     v_q;
	slr_pkg::sq_t             d_q;
	slr_pkg::sq_t             nxt;
	logic [slr_pkg::SQW-1:0]  bitv;
	logic [slr_pkg::SQW-1:0]  trial;

	assign up_hold  = v_q & dn_hold;
	assign dn_valid = v_q;
	assign dn_data  = d_q;

	always_comb begin
		nxt   = up_data;
		bitv  = slr_pkg::SQW'(1) << {step, 1'b0};
		trial = up_data.res + bitv;
		if (up_data.x >= trial) begin
			nxt.x   = up_data.x - trial;
			nxt.res = (up_data.res >> 1) + bitv;
		end else begin
			nxt.res = up_data.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!up_hold) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_hold && up_valid) begin
			d_q <= nxt;
		end
	end
endmodule

// File: rtl/slr_div_cell.sv
// One quotient bit of the three-lane pipelined restoring divider.
module slr_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         step,
	input  logic               up_valid,
	output logic               up_hold,
	input  slr_pkg::dv_t       up_data,
	output logic               dn_valid,
	input  logic               dn_hold,
	output slr_pkg::dv_t       dn_data
);
	logic                    v_q;
	slr_pkg::dv_t            d_q;
	slr_pkg::dv_t            nxt;
	logic [slr_pkg::DW-1:0]  cmpv;

	assign up_hold  = v_q & dn_hold;
	assign dn_valid = v_q;
	assign dn_data  = d_q;

	always_comb begin
		nxt  = up_data;
		cmpv = slr_pkg::DW'(up_data.den) << (6'(step) + 6'd16);
		for (int i = 0; i < 3; i++) begin
			if (up_data.rem[i] >= cmpv) begin
				nxt.rem[i] = up_data.rem[i] - cmpv;
				nxt.q[i]   = {up_data.q[i][slr_pkg::QW-2:0], 1'b1};
			end else begin
				nxt.q[i]   = {up_data.q[i][slr_pkg::QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!up_hold) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_hold && up_valid) begin
			d_q <= nxt;
		end
	end
endmodule

// File: rtl/spring_link_relax_step.sv
// Top level of the spring link relaxation pipeline.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------------
//  input   | pos_a_*, pos_b_*, rest_length, pins, mode | in  | in_valid / in_ready
//  result  | new_a_*, new_b_*, delta_*, coincident     | out | out_valid / out_ready
//  config  | cfg_index, cfg_data                       | in  | cfg_we, no wait
//
// One item enters per cycle while in_ready is high; each item passes 57 register
// stages on its way to the output register: three front stages, 25 square-root
// cells, two multiply stages, 26 divider cells and the output stage.
// Reset clears every stage valid bit and loads the default gains.
// Each stage holds only while it is full and its successor holds, so empty
// stages keep draining toward a stalled output and in_ready drops only when
// every stage is full.
module spring_link_relax_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pos_a_x,
	input  logic [23:0] pos_a_y,
	input  logic [23:0] pos_a_z,
	input  logic [23:0] pos_b_x,
	input  logic [23:0] pos_b_y,
	input  logic [23:0] pos_b_z,
	input  logic [22:0] rest_length,
	input  logic        pinned_a,
	input  logic        pinned_b,
	input  logic        vertical_only,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] new_a_x,
	output logic [23:0] new_a_y,
	output logic [23:0] new_a_z,
	output logic [23:0] new_b_x,
	output logic [23:0] new_b_y,
	output logic [23:0] new_b_z,
	output logic [23:0] delta_x,
	output logic [23:0] delta_y,
	output logic [23:0] delta_z,
	output logic        coincident
);
	localparam int NSQ = slr_pkg::SQ_STEPS;
	localparam int NDV = slr_pkg::DIV_STEPS;

	// Gain registers; the user must write them only while idle, the block does not enforce it.
	logic [slr_pkg::GW-1:0] spring_gain_q;
	logic [slr_pkg::GW-1:0] vertical_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_gain_q   <= slr_pkg::SPRING_GAIN_RST;
			vertical_gain_q <= slr_pkg::VERTICAL_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slr_pkg::CFG_SPRING_GAIN:   spring_gain_q   <= cfg_data;
				slr_pkg::CFG_VERTICAL_GAIN: vertical_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: coordinate differences, split into magnitude and sign.
	logic [2:0][23:0] in_a, in_b;
	assign in_a = {pos_a_z, pos_a_y, pos_a_x};
	assign in_b = {pos_b_z, pos_b_y, pos_b_x};

	slr_pkg::sq_t f1_nxt, f1_s1, f2_s2, f3_s3;
	logic f1_v_s1, f2_v_s2, f3_v_s3;
	logic f1_hold, f2_hold, f3_hold;
	logic [2:0][2*slr_pkg::AW-1:0] sq_s2;

	always_comb begin
		logic signed [slr_pkg::AW-1:0] d;
		f1_nxt           = '0;
		f1_nxt.pos.a     = in_a;
		f1_nxt.pos.b     = in_b;
		f1_nxt.pos.pin_a = pinned_a;
		f1_nxt.pos.pin_b = pinned_b;
		f1_nxt.rest      = rest_length;
		f1_nxt.vert      = vertical_only;
		for (int i = 0; i < 3; i++) begin
			d = slr_pkg::AW'($signed(in_a[i])) - slr_pkg::AW'($signed(in_b[i]));
			f1_nxt.sgn[i] = d[slr_pkg::AW-1];
			f1_nxt.ad[i]  = d[slr_pkg::AW-1] ? slr_pkg::AW'(-d) : slr_pkg::AW'(d);
		end
	end

	assign f1_hold  = f1_v_s1 & f2_hold;
	assign in_ready = !f1_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v_s1 <= 1'b0;
		end else if (!f1_hold) begin
			f1_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!f1_hold && in_valid) begin
			f1_s1 <= f1_nxt;
		end
	end

	// Stage 2: squares of the differences.
	assign f2_hold = f2_v_s2 & f3_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f2_v_s2 <= 1'b0;
		end else if (!f2_hold) begin
			f2_v_s2 <= f1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!f2_hold && f1_v_s1) begin
			f2_s2 <= f1_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= f1_s1.ad[i] * f1_s1.ad[i];
			end
		end
	end

	// Stage 3: sum of squares seeds the root; flag coincident points outside vertical mode.
	slr_pkg::sq_t sq_d [0:NSQ];
	logic         sq_v [0:NSQ];
	logic         sq_h [0:NSQ];

	assign f3_hold = f3_v_s3 & sq_h[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f3_v_s3 <= 1'b0;
		end else if (!f3_hold) begin
			f3_v_s3 <= f2_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [slr_pkg::SQW-1:0] sum;
		if (!f3_hold && f2_v_s2) begin
			sum = slr_pkg::SQW'(sq_s2[0]) + slr_pkg::SQW'(sq_s2[1])
				+ slr_pkg::SQW'(sq_s2[2]);
			f3_s3      <= f2_s2;
			f3_s3.x    <= sum;
			f3_s3.res  <= '0;
			f3_s3.coin <= (sum == '0) && !f2_s2.vert;
		end
	end

	assign sq_d[0] = f3_s3;
	assign sq_v[0] = f3_v_s3;

	// Square-root chain, two radicand bits per cell, most significant first.
	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		slr_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (5'(NSQ - 1 - j)),
			.up_valid (sq_v[j]),
			.up_hold  (sq_h[j]),
			.up_data  (sq_d[j]),
			.dn_valid (sq_v[j+1]),
			.dn_hold  (sq_h[j+1]),
			.dn_data  (sq_d[j+1])
		);
	end

	// Stage M1: length error and |d| * |err|.
	slr_pkg::sq_t m1_s1;
	logic [slr_pkg::MW-1:0]             m1_mag_s1;
	logic [2:0]                         m1_neg_s1;
	logic [2:0][slr_pkg::PRW-1:0]       m1_prod_s1;
	logic m1_v_s1, m1_hold, m2_v_s2, m2_hold;

	assign m1_hold          = m1_v_s1 & m2_hold;
	assign sq_h[NSQ]        = m1_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_v_s1 <= 1'b0;
		end else if (!m1_hold) begin
			m1_v_s1 <= sq_v[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		logic [slr_pkg::MW-1:0]  mag;
		logic signed [26:0]      err;
		logic [slr_pkg::MW-1:0]  eabs;
		if (!m1_hold && sq_v[NSQ]) begin
			mag  = sq_d[NSQ].res[slr_pkg::MW-1:0];
			err  = $signed({1'b0, mag}) - $signed({4'b0, sq_d[NSQ].rest});
			eabs = err[26] ? slr_pkg::MW'(-err) : slr_pkg::MW'(err);
			m1_s1     <= sq_d[NSQ];
			m1_mag_s1 <= mag;
			for (int i = 0; i < 3; i++) begin
				m1_neg_s1[i]  <= sq_d[NSQ].sgn[i] ^ err[26];
				m1_prod_s1[i] <= slr_pkg::PRW'(sq_d[NSQ].ad[i] * eabs);
			end
		end
	end

	// Stage M2: apply the gain and pick the divisor for the mode.
	slr_pkg::dv_t dv_d [0:NDV];
	logic         dv_v [0:NDV];
	logic         dv_h [0:NDV];
	slr_pkg::dv_t m2_s2;

	assign m2_hold = m2_v_s2 & dv_h[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m2_v_s2 <= 1'b0;
		end else if (!m2_hold) begin
			m2_v_s2 <= m1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m2_hold && m1_v_s1) begin
			m2_s2.pos  <= m1_s1.pos;
			m2_s2.coin <= m1_s1.coin;
			m2_s2.q    <= '0;
			if (m1_s1.vert) begin
				// Height pull: divide by 65536 only, y lane alone.
				m2_s2.rem[0] <= '0;
				m2_s2.rem[1] <= slr_pkg::DW'(m1_s1.ad[1] * vertical_gain_q);
				m2_s2.rem[2] <= '0;
				m2_s2.neg    <= {1'b0, m1_s1.sgn[1], 1'b0};
				m2_s2.den    <= slr_pkg::MW'(1);
			end else if (m1_s1.coin) begin
				m2_s2.rem <= '0;
				m2_s2.neg <= '0;
				m2_s2.den <= slr_pkg::MW'(1);
			end else begin
				for (int i = 0; i < 3; i++) begin
					m2_s2.rem[i] <= slr_pkg::DW'(m1_prod_s1[i] * spring_gain_q);
				end
				m2_s2.neg <= m1_neg_s1;
				m2_s2.den <= m1_mag_s1;
			end
		end
	end

	assign dv_d[0] = m2_s2;
	assign dv_v[0] = m2_v_s2;

	// Divider chain, one quotient bit per cell, most significant first.
	for (genvar j = 0; j < NDV; j++) begin : g_div
		slr_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (5'(NDV - 1 - j)),
			.up_valid (dv_v[j]),
			.up_hold  (dv_h[j]),
			.up_data  (dv_d[j]),
			.dn_valid (dv_v[j+1]),
			.dn_hold  (dv_h[j+1]),
			.dn_data  (dv_d[j+1])
		);
	end

	// Output stage: sign and saturate the correction, move unpinned ends.
	logic o_v_q, o_hold;
	logic [2:0][23:0] na_q, nb_q, dl_q;
	logic coin_q;

	assign o_hold    = o_v_q & !out_ready;
	assign dv_h[NDV] = o_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
		end else if (!o_hold) begin
			o_v_q <= dv_v[NDV];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [27:0] s;
		logic [23:0]        dl;
		if (!o_hold && dv_v[NDV]) begin
			for (int i = 0; i < 3; i++) begin
				s  = $signed({2'b00, dv_d[NDV].q[i]});
				s  = dv_d[NDV].neg[i] ? -s : s;
				dl = slr_pkg::sat24(s);
				dl_q[i] <= dl;
				na_q[i] <= dv_d[NDV].pos.pin_a ? dv_d[NDV].pos.a[i]
					: slr_pkg::sat24(28'($signed(dv_d[NDV].pos.a[i])) - 28'($signed(dl)));
				nb_q[i] <= dv_d[NDV].pos.pin_b ? dv_d[NDV].pos.b[i]
					: slr_pkg::sat24(28'($signed(dv_d[NDV].pos.b[i])) + 28'($signed(dl)));
			end
			coin_q <= dv_d[NDV].coin;
		end
	end

	assign out_valid  = o_v_q;
	assign new_a_x    = na_q[0];
	assign new_a_y    = na_q[1];
	assign new_a_z    = na_q[2];
	assign new_b_x    = nb_q[0];
	assign new_b_y    = nb_q[1];
	assign new_b_z    = nb_q[2];
	assign delta_x    = dl_q[0];
	assign delta_y    = dl_q[1];
	assign delta_z    = dl_q[2];
	assign coincident = coin_q;

`ifndef SYNTHESIS
	// A coincident result never carries a correction.
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coincident |-> delta_x == '0 && delta_y == '0 && delta_z == '0)
		else $error("coincident result with nonzero delta");

	// Input stalls only when the output itself is stalled.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// The divider never sees a zero divisor.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m2_v_s2 |-> m2_s2.den != '0)
		else $error("zero divisor entered divider");

	// A held output stage keeps its result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(delta_x) && $stable(new_a_x))
		else $error("stalled result changed");
`endif
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the spring link relaxation pipeline.
`timescale 1ns / 1ps

module tb_top;

	// One link as offered on the input channel; hold_for_drain makes the
	// driver wait with it until every outstanding result has come back.
	typedef struct packed {
		logic [2:0][23:0] a;
		logic [2:0][23:0] b;
		logic [22:0]      rest;
		logic             pin_a;
		logic             pin_b;
		logic             vert;
		logic             hold_for_drain;
	} link_t;

	// Order of words: new a x/y/z, new b x/y/z, delta x/y/z.
	typedef struct packed {
		logic [8:0][23:0] word;
		logic             coin;
	} relax_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = slr_pkg::CFG_SPRING_GAIN;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	link_t       cur = '0;
	relax_t      got;

	link_t       pend_q[$];
	relax_t      relaxed_q[$];
	logic [15:0] k_spring = slr_pkg::SPRING_GAIN_RST;
	logic [15:0] k_vert = slr_pkg::VERTICAL_GAIN_RST;
	logic        took_in = 1'b0;
	logic        calm = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_asks = 0;
	int          holds_done = 0;
	int          errors = 0;
	int          n_in = 0;
	int          n_out = 0;
	int          n_coin = 0;

	string word_name[9] = '{"new_a_x", "new_a_y", "new_a_z", "new_b_x", "new_b_y",
		"new_b_z", "delta_x", "delta_y", "delta_z"};

	spring_link_relax_step dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_a_x(cur.a[0]), .pos_a_y(cur.a[1]), .pos_a_z(cur.a[2]),
		.pos_b_x(cur.b[0]), .pos_b_y(cur.b[1]), .pos_b_z(cur.b[2]),
		.rest_length(cur.rest), .pinned_a(cur.pin_a), .pinned_b(cur.pin_b),
		.vertical_only(cur.vert),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_a_x(got.word[0]), .new_a_y(got.word[1]), .new_a_z(got.word[2]),
		.new_b_x(got.word[3]), .new_b_y(got.word[4]), .new_b_z(got.word[5]),
		.delta_x(got.word[6]), .delta_y(got.word[7]), .delta_z(got.word[8]),
		.coincident(got.coin)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [23:0] clip24(longint v);
		if (v > 64'sd8388607) begin
			return 24'h7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'h800000;
		end
		return v[23:0];
	endfunction

	// Bitwise integer square root, floor.
	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned bit_w;
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > x) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (x >= r + bit_w) begin
				x = x - (r + bit_w);
				r = (r >> 1) + bit_w;
			end else begin
				r = r >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return r;
	endfunction

	// Work out the relaxed positions and correction of one link.
	function automatic relax_t relax_link(link_t l);
		relax_t          r;
		longint          a[3];
		longint          b[3];
		longint          d[3];
		longint          corr[3];
		longint unsigned ad[3];
		longint unsigned sum;
		longint unsigned len;
		longint unsigned eabs;
		longint unsigned prod;
		longint unsigned c;
		longint          err;
		r = '0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(l.a[i]);
			b[i] = $signed(l.b[i]);
			d[i] = a[i] - b[i];
			ad[i] = (d[i] < 0) ? -d[i] : d[i];
			corr[i] = 0;
			sum += ad[i] * ad[i];
		end
		if (l.vert) begin
			c = (ad[1] * k_vert) >> 16;
			corr[1] = (d[1] < 0) ? -longint'(c) : longint'(c);
		end else if (sum == 0) begin
			r.coin = 1'b1;
		end else begin
			len = root_floor(sum);
			err = longint'(len) - longint'(l.rest);
			eabs = (err < 0) ? -err : err;
			for (int i = 0; i < 3; i++) begin
				// exact trunc(|d| * |err| * gain / (len * 65536))
				prod = ad[i] * eabs;
				c = ((prod / len) * k_spring + ((prod % len) * k_spring) / len) >> 16;
				corr[i] = ((d[i] < 0) != (err < 0)) ? -longint'(c) : longint'(c);
			end
		end
		for (int i = 0; i < 3; i++) begin
			corr[i] = longint'($signed(clip24(corr[i])));
			r.word[i] = l.pin_a ? l.a[i] : clip24(a[i] - corr[i]);
			r.word[3+i] = l.pin_b ? l.b[i] : clip24(b[i] + corr[i]);
			r.word[6+i] = corr[i][23:0];
		end
		return r;
	endfunction

	// Random link: mostly nearby points so the spring does real work,
	// with some wide spreads, coincident pairs and rail values mixed in.
	function automatic link_t rand_link();
		link_t l;
		int    kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			l.a[i] = 24'($urandom());
			case (kind)
				0, 1: begin
					l.b[i] = 24'($urandom());
				end
				7: begin
					l.b[i] = l.a[i];
				end
				8: begin
					l.a[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
					l.b[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
				end
				default: begin
					l.b[i] = l.a[i] + 24'($signed($urandom_range(0, 16383)) - 8192);
				end
			endcase
		end
		l.rest = (kind < 2 || kind == 8) ? 23'($urandom()) : 23'($urandom_range(0, 8192));
		l.pin_a = $urandom_range(0, 3) == 0;
		l.pin_b = $urandom_range(0, 3) == 0;
		l.vert = $urandom_range(0, 3) == 0;
		l.hold_for_drain = 1'b0;
		return l;
	endfunction

	function automatic link_t flat_link(logic [23:0] av, logic [23:0] bv, logic [22:0] rest,
		logic pa, logic pb, logic vm);
		link_t l;
		for (int i = 0; i < 3; i++) begin
			l.a[i] = av;
			l.b[i] = bv;
		end
		l.rest = rest;
		l.pin_a = pa;
		l.pin_b = pb;
		l.vert = vm;
		l.hold_for_drain = 1'b0;
		return l;
	endfunction

	// Write one gain register; only called while the pipeline is empty.
	task automatic write_gain(logic idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == slr_pkg::CFG_SPRING_GAIN) begin
			k_spring = v;
		end else begin
			k_vert = v;
		end
	endtask

	task automatic wait_empty();
		while (pend_q.size() != 0 || in_valid || relaxed_q.size() != 0) @(posedge clk);
	endtask

	// Driver: present the next pending item once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_in)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pend_q.size() != 0 &&
				!(pend_q[0].hold_for_drain && relaxed_q.size() != 0)) begin
				cur <= pend_q.pop_front();
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(1, 18);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus long holds on request.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done < hold_asks) begin
			holds_done <= holds_done + 1;
			stall_left <= 300;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Input monitor: predict each accepted item.
	always @(posedge clk) begin
		took_in <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			relaxed_q.push_back(relax_link(cur));
			n_in++;
		end
	end

	// Output monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		relax_t want;
		if (out_valid && out_ready) begin
			n_out++;
			if (got.coin) begin
				n_coin++;
			end
			if (relaxed_q.size() == 0) begin
				$display("%0t: result with nothing expected, got %h", $time, got);
				errors++;
			end else begin
				want = relaxed_q.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (got.word[i] !== want.word[i]) begin
						$display("%0t: %s expected %h actual %h", $time, word_name[i],
							want.word[i], got.word[i]);
						errors++;
					end
				end
				if (got.coin !== want.coin) begin
					$display("%0t: coincident expected %b actual %b", $time, want.coin,
						got.coin);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		link_t l;
		logic [15:0] gains[5][2];
		gains = '{'{16'd0, 16'd0}, '{16'hFFFF, 16'hFFFF}, '{16'd1, 16'd1},
			'{16'h8000, 16'h1234}, '{16'd6554, 16'd655}};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed links at the reset gains.
		pend_q.push_back(flat_link(24'h7FFFFF, 24'h800000, 23'd0, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h800000, 24'h7FFFFF, 23'h7FFFFF, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h123456, 24'h123456, 23'd100, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h000000, 24'h000000, 23'd0, 1'b1, 1'b1, 1'b0));
		pend_q.push_back(flat_link(24'h7FFFFF, 24'h800000, 23'd0, 1'b0, 1'b0, 1'b1));
		pend_q.push_back(flat_link(24'h800000, 24'h7FFFFF, 23'd5, 1'b1, 1'b0, 1'b1));
		pend_q.push_back(flat_link(24'h000500, 24'h000500, 23'd0, 1'b0, 1'b0, 1'b1));
		pend_q.push_back(flat_link(24'h000100, 24'h000000, 23'd0, 1'b1, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h000100, 24'h000000, 23'h7FFFFF, 1'b0, 1'b1, 1'b0));
		pend_q.push_back(flat_link(24'hFFFF00, 24'h000300, 23'd200, 1'b1, 1'b1, 1'b0));
		pend_q.push_back(flat_link(24'h7FFF00, 24'h7FFFFF, 23'd1000, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h000001, 24'h000000, 23'd1, 1'b0, 1'b0, 1'b0));
		wait_empty();

		// Full-scale gains on the rails to drive delta and positions into saturation.
		write_gain(slr_pkg::CFG_SPRING_GAIN, 16'hFFFF);
		write_gain(slr_pkg::CFG_VERTICAL_GAIN, 16'hFFFF);
		pend_q.push_back(flat_link(24'h7FFFFF, 24'h800000, 23'd0, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h800000, 24'h7FFFFF, 23'd0, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h7FFFFF, 24'h800000, 23'd0, 1'b0, 1'b0, 1'b1));
		pend_q.push_back(flat_link(24'h7FFFFF, 24'h7FFF00, 23'h7FFFFF, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h800000, 24'h800100, 23'h7FFFFF, 1'b0, 1'b0, 1'b0));
		pend_q.push_back(flat_link(24'h000000, 24'h000000, 23'd7, 1'b0, 1'b0, 1'b0));
		wait_empty();

		// Random phases, one gain pair each; the last runs without idling.
		for (int ph = 0; ph < 5; ph++) begin
			write_gain(slr_pkg::CFG_SPRING_GAIN, gains[ph][0]);
			write_gain(slr_pkg::CFG_VERTICAL_GAIN, gains[ph][1]);
			calm = (ph == 4);
			for (int n = 0; n < 260; n++) begin
				l = rand_link();
				// pause the sender mid-phase until the pipeline drains
				l.hold_for_drain = (ph == 1 && n == 130);
				pend_q.push_back(l);
			end
			// stall the receiver long enough to back the whole pipeline up
			if (ph == 2) begin
				hold_asks = hold_asks + 1;
			end
			wait_empty();
		end

		repeat (100) @(posedge clk);
		$display("Covered %0d links over seven gain settings, %0d results checked, %0d coincident.",
			n_in, n_out, n_coin);
		$display("Included rail values, saturation, pinned ends, vertical mode and backpressure.");
		if (errors == 0 && relaxed_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
